FILE: sv/dnv_pkg.sv
`default_nettype none
package dnv_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned LabelW = 8;
	localparam int unsigned DotW   = 8;
	localparam int unsigned LenW   = 10;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 10;

	localparam logic [CfgIdxW-1:0] CFG_MAX_LABEL = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_DOT   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_NAME  = 2'd2;

	localparam logic [LabelW-1:0] MAX_LABEL_RST = 8'd63;
	localparam logic [DotW-1:0]   MAX_DOT_RST   = 8'd127;
	localparam logic [LenW-1:0]   MAX_NAME_RST  = 10'd255;
	localparam logic [LenW-1:0]   LEN_SAT       = 10'd1023;

	localparam logic [CharW-1:0] CH_DOT    = 8'h2E;
	localparam logic [CharW-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [CharW-1:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic [LabelW-1:0] max_label;
		logic [DotW-1:0]   max_dot;
		logic [LenW-1:0]   max_name;
	} cfg_t;

	// per-name check state; prev == NUL means start of name
	typedef struct packed {
		logic [CharW-1:0]  prev;
		logic [LabelW-1:0] label;
		logic [DotW-1:0]   dots;
		logic              failed;
	} chk_t;

	localparam chk_t CHK_RST = '{prev: CH_NUL, label: '0, dots: '0, failed: 1'b0};

	function automatic logic is_alnum(input logic [CharW-1:0] ch);
		return ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	// check one character, knowing whether a dot or the end follows it
	function automatic chk_t check_char(input chk_t s, input logic [CharW-1:0] ch,
			input logic next_dot, input logic at_end, input cfg_t cfg);
		chk_t r;
		logic an;
		logic stop;
		r = s;
		an = is_alnum(ch);
		stop = 1'b0;
		if (!s.failed) begin
			if (ch == CH_DOT) begin
				if (s.dots >= cfg.max_dot) begin
					r.failed = 1'b1;
					stop = 1'b1;
				end else begin
					r.dots = s.dots + 8'd1;
				end
			end else begin
				if (s.label >= cfg.max_label) begin
					r.failed = 1'b1;
					stop = 1'b1;
				end else begin
					r.label = s.label + 8'd1;
				end
			end
			if (!stop && (s.prev == CH_DOT || s.prev == CH_NUL) && !an) begin
				r.failed = 1'b1;
				stop = 1'b1;
			end
			if (!stop) begin
				if (at_end || next_dot) begin
					r.label = '0;
					if (ch == CH_DOT && at_end && r.dots > 8'd1) begin
						r.prev = ch;
					end else if (!an) begin
						r.failed = 1'b1;
					end else if (at_end && r.dots == cfg.max_dot) begin
						r.failed = 1'b1;
					end else begin
						r.prev = ch;
					end
				end else if (!an && ch != CH_DOT && ch != CH_HYPHEN) begin
					r.failed = 1'b1;
				end else begin
					r.prev = ch;
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/dnv_in_if.sv
`default_nettype none
interface dnv_in_if
	import dnv_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] character;
	logic             final_char;

	modport source(output valid, output character, output final_char, input ready);
	modport sink(input valid, input character, input final_char, output ready);
endinterface
`default_nettype wire

FILE: sv/dnv_out_if.sv
`default_nettype none
interface dnv_out_if
	import dnv_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            name_valid;
	logic [LenW-1:0] name_length;

	modport source(output valid, output name_valid, output name_length, input ready);
	modport sink(input valid, input name_valid, input name_length, output ready);
endinterface
`default_nettype wire

FILE: sv/dnv_core.sv
`default_nettype none
module dnv_core
	import dnv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [CharW-1:0] ch,
	input  wire logic             last,
	input  wire cfg_t             cfg,
	output logic                  name_valid,
	output logic [LenW-1:0]       name_length
);

	chk_t             st_q;
	logic [CharW-1:0] pend_q;
	logic             have_pend_q;
	logic [LenW-1:0]  seen_q;

	chk_t            s0;
	chk_t            s1;
	chk_t            s2;
	logic [LenW-1:0] seen_nx;

	always_comb begin
		s0 = st_q;
		s0.failed = st_q.failed | (seen_q >= cfg.max_name);
		seen_nx = (seen_q != LEN_SAT) ? seen_q + 10'd1 : seen_q;
		s1 = have_pend_q ? check_char(s0, pend_q, ch == CH_DOT, 1'b0, cfg) : s0;
		s2 = check_char(s1, ch, 1'b0, 1'b1, cfg);
	end

	assign name_valid  = ~s2.failed;
	assign name_length = seen_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= CHK_RST;
			pend_q      <= CH_NUL;
			have_pend_q <= 1'b0;
			seen_q      <= '0;
		end else if (step) begin
			if (last) begin
				st_q        <= CHK_RST;
				pend_q      <= CH_NUL;
				have_pend_q <= 1'b0;
				seen_q      <= '0;
			end else begin
				st_q        <= s1;
				pend_q      <= ch;
				have_pend_q <= 1'b1;
				seen_q      <= seen_nx;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/dns_name_validator.sv
// Streaming host name checker. Characters arrive one item per cycle on chars,
// final_char set on the last one; exactly one result (name_valid, name_length)
// leaves on results per name. Each item passes an input register, then the
// per-character checks and a result register: a result is loaded as its
// final character leaves the input register; one item per cycle is sustained
// unless input is held back, which happens only while a finished result waits
// on results and the next final character sits in the input register. The
// limit registers take effect from the next character checked.
`default_nettype none
module dns_name_validator
	import dnv_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	dnv_in_if.sink                   chars,
	dnv_out_if.source                results,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg_q;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             final_s1;

	logic            out_valid_q;
	logic            out_name_valid_q;
	logic [LenW-1:0] out_len_q;

	logic            advance;
	logic            res_valid;
	logic [LenW-1:0] res_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_label <= MAX_LABEL_RST;
			cfg_q.max_dot   <= MAX_DOT_RST;
			cfg_q.max_name  <= MAX_NAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LABEL: cfg_q.max_label <= cfg_data[LabelW-1:0];
				CFG_MAX_DOT:   cfg_q.max_dot   <= cfg_data[DotW-1:0];
				CFG_MAX_NAME:  cfg_q.max_name  <= cfg_data[LenW-1:0];
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 & (~final_s1 | ~out_valid_q | results.ready);
	assign chars.ready  = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1  <= chars.character;
			final_s1 <= chars.final_char;
		end
	end

	dnv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.ch          (char_s1),
		.last        (final_s1),
		.cfg         (cfg_q),
		.name_valid  (res_valid),
		.name_length (res_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			out_name_valid_q <= res_valid;
			out_len_q        <= res_len;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.name_valid  = out_name_valid_q;
	assign results.name_length = out_len_q;

endmodule
`default_nettype wire

FILE: sv/dnv_checker.sv
`default_nettype none
module dnv_checker
	import dnv_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            in_final,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic            out_name_valid,
	input wire logic [LenW-1:0] out_length
);

	logic fire_final;
	assign fire_final = in_valid & in_ready & in_final;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_name_valid)
			&& $stable(out_length))
		else $error("result changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_length != '0)
		else $error("result with zero length");

	a_rise_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire_final, 2))
		else $error("result without a final item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with no waiting result");

endmodule

bind dns_name_validator dnv_checker u_dnv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (chars.valid),
	.in_ready       (chars.ready),
	.in_final       (chars.final_char),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_name_valid (results.name_valid),
	.out_length     (results.name_length)
);
`default_nettype wire
